@@ rtl/core/vkss_pkg.sv @@
package vkss_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);

    localparam int MUL_AW = 33;
    localparam int MUL_BW = 32;
    localparam int MUL_CW = $clog2(MUL_BW);
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 41;
    localparam int DIV_CW = $clog2(DIV_NW);

    localparam logic [1:0] CFG_WHEELBASE = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [1:0] CFG_YAW_LIMIT = 2'd2;

    localparam logic [9:0]  WHEELBASE_RST = 10'd150;
    localparam logic [13:0] MAX_SPEED_RST = 14'd8192;
    localparam logic [14:0] YAW_LIMIT_RST = 15'd16384;
    localparam logic [13:0] SPEED_RST     = 14'd2048;

    localparam logic [9:0]  WHEELBASE_MIN = 10'd10;
    localparam logic [9:0]  WHEELBASE_MAX = 10'd1000;
    localparam logic [6:0]  THR_MAX       = 7'd100;
    localparam logic signed [6:0] STEER_MAX = 7'sd45;
    localparam logic [19:0] DT_MIN        = 20'd1000;
    localparam logic [19:0] DT_MAX        = 20'd100000;

    localparam logic signed [MUL_AW-1:0] CORDIC_GAIN_Q30 = 33'sh026DD3B6A;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
    localparam logic [23:0] STEER_Q30_PER_DEG  = 24'd14992264;

    localparam logic signed [16:0] ROLLING_Q12 = 17'sd410;
    localparam logic signed [16:0] MAX_ACC_Q12 = 17'sd12288;
    localparam logic signed [16:0] MAX_DEC_Q12 = 17'sd16384;
    localparam logic [13:0] MIN_TURN_SPEED_Q12 = 14'd409;
    localparam logic [13:0] THR_SCALE_Q12      = 14'd12288;
    localparam logic [10:0] SPEED_TO_RATE      = 11'd2000;
    localparam logic [DIV_DW-1:0] US_PER_S     = 41'd1000000;
    localparam logic [DIV_DW-1:0] PCT_DIV      = 41'd100;
    localparam logic [DIV_DW-1:0] DRAG_DIV     = 41'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VV_MUL,
        ST_VV_DIV,
        ST_THR_DIV,
        ST_ADT_MUL,
        ST_ADT_DIV,
        ST_VDT_MUL,
        ST_VDT_DIV,
        ST_HEAD_COR,
        ST_X_MUL,
        ST_Y_MUL,
        ST_STEER_COR,
        ST_NUM_MUL,
        ST_DEN_MUL,
        ST_RATE_DIV,
        ST_RDT_MUL,
        ST_RDT_DIV,
        ST_DONE
    } t_state;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/vehicle_kinematic_state_step_core.sv @@
// Handles one input transaction at a time, using the bit-serial multiplier, the
// bit-serial divider and the 16-step CORDIC one after another; the steering steps
// run only when turning. A new transaction is accepted only after the previous
// result is loaded into the output register, where a finished result waits.
// Reset (synchronous, active low): position 0, speed 0.5 m/s, heading 0, registers
// to their defaults.
module vehicle_kinematic_state_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [14:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // thr_pct[6:0], steer_deg[13:7], dt_us[33:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // pos_x_q12[31:0], pos_y_q12[63:32],
                                        // speed_q12[77:64], yaw_q13[93:78]
);

    vkss_pkg::t_state r_state, n_state, st_after;
    logic r_go, n_go;

    logic [9:0]  r_wheelbase;
    logic [13:0] r_max_speed;
    logic [14:0] r_yaw_limit;

    logic [31:0]        r_pos_x, r_pos_y;
    logic [13:0]        r_speed;
    logic signed [15:0] r_heading;

    logic [6:0]         r_thr;
    logic signed [6:0]  r_steer;
    logic [16:0]        r_dt;
    logic [11:0]        r_qvv;
    logic signed [15:0] r_acc;
    logic [10:0]        r_dist;
    logic               r_flip;
    logic signed [32:0] r_cos, r_sin;
    logic [55:0]        r_num;
    logic [40:0]        r_den;
    logic [14:0]        r_rate;

    logic        r_out_valid;
    logic [95:0] r_out_data;

    // multiplier
    logic signed [vkss_pkg::MUL_AW-1:0] r_mul_a;
    logic signed [vkss_pkg::MUL_AW:0]   r_mul_hi;
    logic [vkss_pkg::MUL_BW-1:0]        r_mul_lo;
    logic [vkss_pkg::MUL_CW-1:0]        r_mul_cnt;
    logic                               r_mul_run;
    logic signed [vkss_pkg::MUL_AW:0]   mul_add, mul_sum;
    logic signed [65:0]                 mul_p;
    logic                               use_mul, mul_start;
    logic signed [vkss_pkg::MUL_AW-1:0] mul_a;
    logic [vkss_pkg::MUL_BW-1:0]        mul_b;

    // divider
    logic [vkss_pkg::DIV_NW-1:0] r_div_q;
    logic [vkss_pkg::DIV_DW-1:0] r_div_rem, r_div_d;
    logic [vkss_pkg::DIV_CW-1:0] r_div_cnt;
    logic                        r_div_run;
    logic [vkss_pkg::DIV_DW:0]   div_trial;
    logic                        div_ge;
    logic [vkss_pkg::DIV_DW:0]   div_rem_n;
    logic                        use_div, div_start;
    logic [vkss_pkg::DIV_NW-1:0] div_n;
    logic [vkss_pkg::DIV_DW-1:0] div_d;

    // CORDIC
    logic signed [32:0]                r_cx, r_cy;
    logic signed [33:0]                r_cz;
    logic [vkss_pkg::CORDIC_IW-1:0]    r_ci;
    logic                              r_cor_run;
    logic signed [32:0]                cor_xs, cor_ys;
    logic signed [33:0]                cor_at;
    logic                              use_cor, cor_start;
    logic signed [33:0]                cor_z;

    logic               phase_done;
    logic               accept;
    logic               out_load;
    logic signed [33:0] head_z;
    logic               head_flip;
    logic [6:0]         steer_abs;
    logic [5:0]         steer_mag;
    logic [9:0]         wb_sat;
    logic [24:0]        v2000;
    logic signed [31:0] adt_p;
    logic [31:0]        adt_mag;
    logic signed [16:0] acc_raw, acc_clamp;
    logic signed [16:0] v_delta, v_sum;
    logic [13:0]        v_new;
    logic signed [16:0] h_sum, h_new;
    logic               turn;

    assign s_axis_tready = (r_state == vkss_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign phase_done    = r_go && !r_mul_run && !r_div_run && !r_cor_run;
    assign out_load      = (r_state == vkss_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);

    assign steer_abs = r_steer[6] ? 7'(-r_steer) : 7'(r_steer);
    assign steer_mag = steer_abs[5:0];
    assign wb_sat    = (r_wheelbase < vkss_pkg::WHEELBASE_MIN) ? vkss_pkg::WHEELBASE_MIN :
                       (r_wheelbase > vkss_pkg::WHEELBASE_MAX) ? vkss_pkg::WHEELBASE_MAX :
                       r_wheelbase;
    assign v2000     = 25'(r_speed) * 25'(vkss_pkg::SPEED_TO_RATE);
    assign turn      = (r_steer != 7'sd0) && (r_speed > vkss_pkg::MIN_TURN_SPEED_Q12);

    always_comb begin
        head_z    = {r_heading[15], r_heading, 17'b0};
        head_flip = 1'b0;
        if (head_z > vkss_pkg::HALF_PI_Q30) begin
            head_z    = head_z - vkss_pkg::PI_Q30;
            head_flip = 1'b1;
        end else if (head_z < -vkss_pkg::HALF_PI_Q30) begin
            head_z    = head_z + vkss_pkg::PI_Q30;
            head_flip = 1'b1;
        end
    end

    always_comb begin
        acc_raw = $signed({3'b0, r_div_q[13:0]}) - vkss_pkg::ROLLING_Q12
                  - $signed({5'b0, r_qvv});
        if (acc_raw > vkss_pkg::MAX_ACC_Q12) begin
            acc_clamp = vkss_pkg::MAX_ACC_Q12;
        end else if (acc_raw < -vkss_pkg::MAX_DEC_Q12) begin
            acc_clamp = -vkss_pkg::MAX_DEC_Q12;
        end else begin
            acc_clamp = acc_raw;
        end
    end

    assign adt_p   = mul_p[31:0];
    assign adt_mag = adt_p[31] ? 32'(-adt_p) : 32'(adt_p);

    always_comb begin
        v_delta = r_acc[15] ? -$signed({6'b0, r_div_q[10:0]}) : $signed({6'b0, r_div_q[10:0]});
        v_sum   = $signed({3'b0, r_speed}) + v_delta;
        if (v_sum > $signed({3'b0, r_max_speed})) begin
            v_new = r_max_speed;
        end else if (v_sum < 17'sd0) begin
            v_new = '0;
        end else begin
            v_new = v_sum[13:0];
        end
    end

    always_comb begin
        h_sum = r_steer[6] ? $signed({r_heading[15], r_heading}) - $signed({5'b0, r_div_q[11:0]})
                           : $signed({r_heading[15], r_heading}) + $signed({5'b0, r_div_q[11:0]});
        if (h_sum > vkss_pkg::PI_Q13) begin
            h_new = h_sum - vkss_pkg::TWO_PI_Q13;
        end else if (h_sum < -vkss_pkg::PI_Q13) begin
            h_new = h_sum + vkss_pkg::TWO_PI_Q13;
        end else begin
            h_new = h_sum;
        end
    end

    always_comb begin
        use_mul = 1'b0;
        use_div = 1'b0;
        use_cor = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_n   = '0;
        div_d   = vkss_pkg::US_PER_S;
        cor_z   = '0;
        st_after = vkss_pkg::ST_IDLE;
        unique case (r_state)
            vkss_pkg::ST_VV_MUL: begin
                use_mul  = 1'b1;
                mul_a    = $signed({19'b0, r_speed});
                mul_b    = 32'(r_speed);
                st_after = vkss_pkg::ST_VV_DIV;
            end
            vkss_pkg::ST_VV_DIV: begin
                use_div  = 1'b1;
                div_n    = 56'(mul_p[27:14]);
                div_d    = vkss_pkg::DRAG_DIV;
                st_after = vkss_pkg::ST_THR_DIV;
            end
            vkss_pkg::ST_THR_DIV: begin
                use_div  = 1'b1;
                div_n    = 56'(r_thr) * 56'(vkss_pkg::THR_SCALE_Q12);
                div_d    = vkss_pkg::PCT_DIV;
                st_after = vkss_pkg::ST_ADT_MUL;
            end
            vkss_pkg::ST_ADT_MUL: begin
                use_mul  = 1'b1;
                mul_a    = 33'(r_acc);
                mul_b    = 32'(r_dt);
                st_after = vkss_pkg::ST_ADT_DIV;
            end
            vkss_pkg::ST_ADT_DIV: begin
                use_div  = 1'b1;
                div_n    = 56'(adt_mag);
                st_after = vkss_pkg::ST_VDT_MUL;
            end
            vkss_pkg::ST_VDT_MUL: begin
                use_mul  = 1'b1;
                mul_a    = $signed({19'b0, r_speed});
                mul_b    = 32'(r_dt);
                st_after = vkss_pkg::ST_VDT_DIV;
            end
            vkss_pkg::ST_VDT_DIV: begin
                use_div  = 1'b1;
                div_n    = 56'(mul_p[30:0]);
                st_after = vkss_pkg::ST_HEAD_COR;
            end
            vkss_pkg::ST_HEAD_COR: begin
                use_cor  = 1'b1;
                cor_z    = head_z;
                st_after = vkss_pkg::ST_X_MUL;
            end
            vkss_pkg::ST_X_MUL: begin
                use_mul  = 1'b1;
                mul_a    = r_cos;
                mul_b    = 32'(r_dist);
                st_after = vkss_pkg::ST_Y_MUL;
            end
            vkss_pkg::ST_Y_MUL: begin
                use_mul  = 1'b1;
                mul_a    = r_sin;
                mul_b    = 32'(r_dist);
                st_after = turn ? vkss_pkg::ST_STEER_COR : vkss_pkg::ST_DONE;
            end
            vkss_pkg::ST_STEER_COR: begin
                use_cor  = 1'b1;
                cor_z    = $signed(34'(steer_mag) * 34'(vkss_pkg::STEER_Q30_PER_DEG));
                st_after = vkss_pkg::ST_NUM_MUL;
            end
            vkss_pkg::ST_NUM_MUL: begin
                use_mul  = 1'b1;
                mul_a    = $signed({8'b0, v2000});
                mul_b    = r_sin[31:0];
                st_after = vkss_pkg::ST_DEN_MUL;
            end
            vkss_pkg::ST_DEN_MUL: begin
                use_mul  = 1'b1;
                mul_a    = r_cos;
                mul_b    = 32'(wb_sat);
                st_after = vkss_pkg::ST_RATE_DIV;
            end
            vkss_pkg::ST_RATE_DIV: begin
                use_div  = 1'b1;
                div_n    = r_num;
                div_d    = r_den;
                st_after = vkss_pkg::ST_RDT_MUL;
            end
            vkss_pkg::ST_RDT_MUL: begin
                use_mul  = 1'b1;
                mul_a    = $signed({18'b0, r_rate});
                mul_b    = 32'(r_dt);
                st_after = vkss_pkg::ST_RDT_DIV;
            end
            vkss_pkg::ST_RDT_DIV: begin
                use_div  = 1'b1;
                div_n    = 56'(mul_p[31:0]);
                st_after = vkss_pkg::ST_DONE;
            end
            default: begin
                st_after = vkss_pkg::ST_IDLE;
            end
        endcase
    end

    assign mul_start = !r_go && use_mul;
    assign div_start = !r_go && use_div;
    assign cor_start = !r_go && use_cor;

    always_comb begin
        n_state = r_state;
        n_go    = r_go;
        unique case (r_state)
            vkss_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = vkss_pkg::ST_VV_MUL;
                end
            end
            vkss_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = vkss_pkg::ST_IDLE;
                end
            end
            default: begin
                if (!r_go) begin
                    n_go = 1'b1;
                end else if (phase_done) begin
                    n_go    = 1'b0;
                    n_state = st_after;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vkss_pkg::ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase <= vkss_pkg::WHEELBASE_RST;
            r_max_speed <= vkss_pkg::MAX_SPEED_RST;
            r_yaw_limit <= vkss_pkg::YAW_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vkss_pkg::CFG_WHEELBASE: r_wheelbase <= i_cfg_wdata[9:0];
                vkss_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_wdata[13:0];
                vkss_pkg::CFG_YAW_LIMIT: r_yaw_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // multiplier: one multiplier bit per cycle, accumulate and shift right
    assign mul_add = r_mul_lo[0] ? {r_mul_a[vkss_pkg::MUL_AW-1], r_mul_a} : '0;
    assign mul_sum = r_mul_hi + mul_add;
    assign mul_p   = $signed({r_mul_hi, r_mul_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_run <= 1'b0;
        end else if (mul_start) begin
            r_mul_run <= 1'b1;
        end else if (r_mul_run && r_mul_cnt == vkss_pkg::MUL_CW'(vkss_pkg::MUL_BW - 1)) begin
            r_mul_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_mul_a   <= mul_a;
            r_mul_hi  <= '0;
            r_mul_lo  <= mul_b;
            r_mul_cnt <= '0;
        end else if (r_mul_run) begin
            r_mul_hi  <= {mul_sum[vkss_pkg::MUL_AW], mul_sum[vkss_pkg::MUL_AW:1]};
            r_mul_lo  <= {mul_sum[0], r_mul_lo[vkss_pkg::MUL_BW-1:1]};
            r_mul_cnt <= r_mul_cnt + vkss_pkg::MUL_CW'(1);
        end
    end

    // divider: restoring, one quotient bit per cycle
    assign div_trial = {r_div_rem, r_div_q[vkss_pkg::DIV_NW-1]};
    assign div_ge    = div_trial >= {1'b0, r_div_d};
    assign div_rem_n = div_ge ? (div_trial - {1'b0, r_div_d}) : div_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
        end else if (div_start) begin
            r_div_run <= 1'b1;
        end else if (r_div_run && r_div_cnt == vkss_pkg::DIV_CW'(vkss_pkg::DIV_NW - 1)) begin
            r_div_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_div_q   <= div_n;
            r_div_d   <= div_d;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (r_div_run) begin
            r_div_q   <= {r_div_q[vkss_pkg::DIV_NW-2:0], div_ge};
            r_div_rem <= div_rem_n[vkss_pkg::DIV_DW-1:0];
            r_div_cnt <= r_div_cnt + vkss_pkg::DIV_CW'(1);
        end
    end

    // CORDIC: one rotation step per cycle
    assign cor_xs = r_cx >>> r_ci;
    assign cor_ys = r_cy >>> r_ci;
    assign cor_at = $signed({4'b0, vkss_pkg::atan_q30(5'(r_ci))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cor_run <= 1'b0;
        end else if (cor_start) begin
            r_cor_run <= 1'b1;
        end else if (r_cor_run &&
                     r_ci == vkss_pkg::CORDIC_IW'(vkss_pkg::CORDIC_STEPS - 1)) begin
            r_cor_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cor_start) begin
            r_cx <= vkss_pkg::CORDIC_GAIN_Q30;
            r_cy <= '0;
            r_cz <= cor_z;
            r_ci <= '0;
        end else if (r_cor_run) begin
            if (r_cz >= 34'sd0) begin
                r_cx <= r_cx - cor_ys;
                r_cy <= r_cy + cor_xs;
                r_cz <= r_cz - cor_at;
            end else begin
                r_cx <= r_cx + cor_ys;
                r_cy <= r_cy - cor_xs;
                r_cz <= r_cz + cor_at;
            end
            r_ci <= r_ci + vkss_pkg::CORDIC_IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_speed     <= vkss_pkg::SPEED_RST;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (phase_done) begin
                unique case (r_state)
                    vkss_pkg::ST_ADT_DIV:  r_speed   <= v_new;
                    vkss_pkg::ST_X_MUL:    r_pos_x   <= r_pos_x + mul_p[61:30];
                    vkss_pkg::ST_Y_MUL:    r_pos_y   <= r_pos_y + mul_p[61:30];
                    vkss_pkg::ST_RDT_DIV:  r_heading <= h_new[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_thr   <= (s_axis_tdata[6:0] > vkss_pkg::THR_MAX) ? vkss_pkg::THR_MAX
                                                               : s_axis_tdata[6:0];
            if ($signed(s_axis_tdata[13:7]) > vkss_pkg::STEER_MAX) begin
                r_steer <= vkss_pkg::STEER_MAX;
            end else if ($signed(s_axis_tdata[13:7]) < -vkss_pkg::STEER_MAX) begin
                r_steer <= -vkss_pkg::STEER_MAX;
            end else begin
                r_steer <= $signed(s_axis_tdata[13:7]);
            end
            if (s_axis_tdata[33:14] < vkss_pkg::DT_MIN) begin
                r_dt <= vkss_pkg::DT_MIN[16:0];
            end else if (s_axis_tdata[33:14] > vkss_pkg::DT_MAX) begin
                r_dt <= vkss_pkg::DT_MAX[16:0];
            end else begin
                r_dt <= s_axis_tdata[30:14];
            end
        end
        if (cor_start) begin
            r_flip <= (r_state == vkss_pkg::ST_HEAD_COR) && head_flip;
        end
        if (phase_done) begin
            unique case (r_state)
                vkss_pkg::ST_VV_DIV:   r_qvv  <= r_div_q[11:0];
                vkss_pkg::ST_THR_DIV:  r_acc  <= acc_clamp[15:0];
                vkss_pkg::ST_VDT_DIV:  r_dist <= r_div_q[10:0];
                vkss_pkg::ST_HEAD_COR: begin
                    r_cos <= r_flip ? -r_cx : r_cx;
                    r_sin <= r_flip ? -r_cy : r_cy;
                end
                vkss_pkg::ST_STEER_COR: begin
                    r_cos <= r_cx;
                    r_sin <= r_cy[32] ? '0 : r_cy;
                end
                vkss_pkg::ST_NUM_MUL:  r_num  <= mul_p[55:0];
                vkss_pkg::ST_DEN_MUL:  r_den  <= (mul_p <= 66'sd0) ? 41'd1 : mul_p[40:0];
                vkss_pkg::ST_RATE_DIV: r_rate <= (r_div_q > 56'(r_yaw_limit)) ? r_yaw_limit
                                                                            : r_div_q[14:0];
                default: ;
            endcase
        end
        if (out_load) begin
            r_out_data <= {2'b0, r_heading, r_speed, r_pos_y, r_pos_x};
        end
    end

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_mul_run, r_div_run, r_cor_run}) <= 1)
        else $error("arithmetic units overlap");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed({r_heading[15], r_heading}) <= vkss_pkg::PI_Q13) &&
        ($signed({r_heading[15], r_heading}) >= -vkss_pkg::PI_Q13))
        else $error("heading outside wrap range");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(r_mul_run || r_div_run || r_cor_run))
        else $error("unit running while idle");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == vkss_pkg::ST_VV_MUL))
        else $error("transaction did not start sequence");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == vkss_pkg::ST_DONE))
        else $error("result raised outside done");

endmodule
